// ===== src/mrn_pkg.sv =====
// Package for the mesh ring neighbour block: sizes, register map, status codes
// and the configuration struct shared by the register block and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrn_pkg;

  // Largest mesh dimension handled
  localparam int MAX_DIM  = 64;
  // Width of a dimension value (holds 1..MAX_DIM)
  localparam int DIM_W    = 7;
  // Width of a coordinate and of a linear id
  localparam int COORD_W  = 6;
  localparam int ID_W     = 12;

  // Register indexes on the configuration port
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ONE_NODE = 2'd1,
    ST_OUTSIDE  = 2'd2
  } status_t;

  // Effective (clamped) mesh sizes
  typedef struct packed {
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } dims_t;

endpackage

`default_nettype wire

// ===== src/mesh_ring_neighbor.sv =====
// Top level of the mesh ring neighbour block: APB registers, query register,
// ring step logic, id multiply and result register.
// Depends on mrn_pkg, mrn_cfg_regs and mrn_ring_step.
//
//   channel   handshake               payload
//   query     start, busy             node_col, node_row, toward_next
//   result    done (strobe)           neighbor_id, neighbor_col, neighbor_row, status
//   config    psel, penable, pwrite   paddr, pwdata, prdata, pready
//
// One query is taken every cycle; busy stays low. A result appears on done once
// its transfer has passed the query register, then the ring step logic and the
// row-times-width multiply into the result register. Synchronous reset clears the
// pipeline valid bits and sets both sizes to 2. The receiver cannot stall, so
// nothing ever holds the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module mesh_ring_neighbor (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [mrn_pkg::COORD_W-1:0] node_col,
  input  wire logic [mrn_pkg::COORD_W-1:0] node_row,
  input  wire logic                        toward_next,
  output logic                             done,
  output logic [mrn_pkg::ID_W-1:0]         neighbor_id,
  output logic [mrn_pkg::COORD_W-1:0]      neighbor_col,
  output logic [mrn_pkg::COORD_W-1:0]      neighbor_row,
  output logic [1:0]                       status,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import mrn_pkg::*;

  dims_t              dims;
  logic               s1_valid;
  logic [COORD_W-1:0] s1_col;
  logic [COORD_W-1:0] s1_row;
  logic               s1_dir;
  logic [COORD_W-1:0] nb_col;
  logic [COORD_W-1:0] nb_row;
  status_t            stat;
  logic [COORD_W+DIM_W-1:0] id_full;

  assign busy = 1'b0;

  mrn_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims    (dims)
  );

  // Query register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_col <= node_col;
      s1_row <= node_row;
      s1_dir <= toward_next;
    end
  end

  mrn_ring_step u_step (
    .dims   (dims),
    .col    (s1_col),
    .row    (s1_row),
    .fwd    (s1_dir),
    .nb_col (nb_col),
    .nb_row (nb_row),
    .stat   (stat)
  );

  // Linear id: row times width plus column, kept to the id width
  assign id_full = nb_row * dims.w + {{DIM_W{1'b0}}, nb_col};

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      neighbor_id  <= id_full[ID_W-1:0];
      neighbor_col <= nb_col;
      neighbor_row <= nb_row;
      status       <= stat;
    end
  end

  // Every transfer gives its result on done, through the query and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("result strobe missing two cycles after a query transfer");

  // No result without a matching query transfer before it
  a_no_spurious: assert property (@(posedge clk)
    done |-> $past(start, 2))
    else $error("result strobe without a matching query");

  // Error results carry zero id and coordinates
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |->
      (neighbor_id == '0 && neighbor_col == '0 && neighbor_row == '0))
    else $error("error result with non-zero neighbour fields");

endmodule

`default_nettype wire

// ===== src/mrn_cfg_regs.sv =====
// Configuration registers of the mesh ring neighbour block on an APB-style port.
// Holds grid_width and grid_height and hands out the clamped sizes.
// Depends on mrn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrn_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output mrn_pkg::dims_t    dims
);
  import mrn_pkg::*;

  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(2);
      grid_height <= DIM_W'(2);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_GRID_WIDTH:  grid_width  <= pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the raw register values
  always_comb begin
    unique case (paddr[2])
      REG_GRID_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, grid_width};
      REG_GRID_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, grid_height};
      default:         prdata = '0;
    endcase
  end

  // Clamp sizes: zero counts as one, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0)
      return DIM_W'(1);
    else if (v > DIM_W'(MAX_DIM))
      return DIM_W'(MAX_DIM);
    else
      return v;
  endfunction

  assign dims.w = clamp_dim(grid_width);
  assign dims.h = clamp_dim(grid_height);

endmodule

`default_nettype wire

// ===== src/mrn_ring_step.sv =====
// Combinational ring step: neighbour coordinates and status for one node.
// Selects the layout case from the mesh sizes. Depends on mrn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrn_ring_step (
  input  wire mrn_pkg::dims_t            dims,
  input  wire logic [mrn_pkg::COORD_W-1:0] col,
  input  wire logic [mrn_pkg::COORD_W-1:0] row,
  input  wire logic                      fwd,
  output logic [mrn_pkg::COORD_W-1:0]    nb_col,
  output logic [mrn_pkg::COORD_W-1:0]    nb_row,
  output mrn_pkg::status_t               stat
);
  import mrn_pkg::*;

  logic [DIM_W-1:0] w, h, wm1, hm1;
  logic [DIM_W-1:0] x, y, xp, xm, yp, ym;
  logic [DIM_W-1:0] nx, ny, px, py;
  logic             xe, ye;

  assign w   = dims.w;
  assign h   = dims.h;
  assign wm1 = w - DIM_W'(1);
  assign hm1 = h - DIM_W'(1);
  assign x   = {1'b0, col};
  assign y   = {1'b0, row};
  assign xp  = x + DIM_W'(1);
  assign xm  = x - DIM_W'(1);
  assign yp  = y + DIM_W'(1);
  assign ym  = y - DIM_W'(1);
  assign xe  = ~col[0];
  assign ye  = ~row[0];

  // Next node on the ring
  always_comb begin
    nx = x;
    ny = y;
    if (w == DIM_W'(1)) begin
      ny = (y == hm1) ? '0 : yp;
    end else if (h == DIM_W'(1)) begin
      nx = (x == wm1) ? '0 : xp;
    end else if (h == DIM_W'(2)) begin
      if (y == '0) begin
        if (x == wm1) ny = DIM_W'(1); else nx = xp;
      end else begin
        if (x == '0) ny = '0; else nx = xm;
      end
    end else if (w == DIM_W'(2)) begin
      if (x == '0) begin
        if (y == '0) nx = DIM_W'(1); else ny = ym;
      end else begin
        if (y == hm1) nx = '0; else ny = yp;
      end
    end else if (!w[0]) begin
      // even width: top row left to right, vertical snake back
      if (y == '0) begin
        if (x == wm1) ny = DIM_W'(1); else nx = xp;
      end else if (y == DIM_W'(1)) begin
        if (x == '0)      ny = '0;
        else if (x == wm1) ny = DIM_W'(2);
        else if (xe)      nx = xm;
        else              ny = DIM_W'(2);
      end else if (y == hm1) begin
        if (xe) ny = ym; else nx = xm;
      end else begin
        if (xe) ny = ym; else ny = yp;
      end
    end else if (!h[0]) begin
      // even height: transposed layout
      if (x == '0) begin
        if (y == '0) nx = DIM_W'(1); else ny = ym;
      end else if (x == DIM_W'(1)) begin
        if (y == '0)       nx = DIM_W'(2);
        else if (y == hm1) nx = '0;
        else if (ye)       nx = DIM_W'(2);
        else               ny = yp;
      end else if (x == wm1) begin
        if (ye) ny = yp; else nx = xm;
      end else begin
        if (ye) nx = xp; else nx = xm;
      end
    end else begin
      // odd by odd: diagonal step from (1,1) back to (0,0)
      if (y == '0) begin
        if (x == wm1) ny = DIM_W'(1); else nx = xp;
      end else if (x > DIM_W'(1)) begin
        if (y == DIM_W'(1)) begin
          if (x == wm1 || xe) ny = DIM_W'(2); else nx = xm;
        end else if (y == hm1) begin
          if (xe) nx = xm; else ny = ym;
        end else begin
          if (xe) ny = yp; else ny = ym;
        end
      end else if (x == DIM_W'(1) && y == DIM_W'(1)) begin
        nx = '0;
        ny = '0;
      end else if (x == DIM_W'(1) && y == hm1) begin
        nx = '0;
      end else if (x == '0) begin
        if (ye) ny = ym; else nx = DIM_W'(1);
      end else begin
        if (ye) nx = '0; else ny = ym;
      end
    end
  end

  // Previous node on the ring
  always_comb begin
    px = x;
    py = y;
    if (w == DIM_W'(1)) begin
      py = (y == '0) ? hm1 : ym;
    end else if (h == DIM_W'(1)) begin
      px = (x == '0) ? wm1 : xm;
    end else if (h == DIM_W'(2)) begin
      if (y == '0) begin
        if (x == '0) py = DIM_W'(1); else px = xm;
      end else begin
        if (x == wm1) py = '0; else px = xp;
      end
    end else if (w == DIM_W'(2)) begin
      if (x == '0) begin
        if (y == hm1) px = DIM_W'(1); else py = yp;
      end else begin
        if (y == '0) px = '0; else py = ym;
      end
    end else if (!w[0]) begin
      if (y == '0) begin
        if (x == '0) py = DIM_W'(1); else px = xm;
      end else if (y == DIM_W'(1)) begin
        if (x == '0)       py = DIM_W'(2);
        else if (x == wm1) py = '0;
        else if (xe)       py = DIM_W'(2);
        else               px = xp;
      end else if (y == hm1) begin
        if (xe) px = xp; else py = ym;
      end else begin
        if (xe) py = yp; else py = ym;
      end
    end else if (!h[0]) begin
      if (x == '0) begin
        if (y == hm1) px = DIM_W'(1); else py = yp;
      end else if (x == DIM_W'(1)) begin
        if (y == '0)       px = '0;
        else if (y == hm1) px = DIM_W'(2);
        else if (ye)       py = ym;
        else               px = DIM_W'(2);
      end else if (x == wm1) begin
        if (ye) px = xm; else py = ym;
      end else begin
        if (ye) px = xm; else px = xp;
      end
    end else begin
      if (y == '0) begin
        if (x == '0) begin
          px = DIM_W'(1);
          py = DIM_W'(1);
        end else begin
          px = xm;
        end
      end else if (x > DIM_W'(1)) begin
        if (y == DIM_W'(1)) begin
          if (x == wm1) py = '0;
          else if (xe)  px = xp;
          else          py = DIM_W'(2);
        end else if (y == hm1) begin
          if (xe) py = ym; else px = xp;
        end else begin
          if (xe) py = ym; else py = yp;
        end
      end else if (x == DIM_W'(1) && y == DIM_W'(1)) begin
        px = '0;
      end else if (x == DIM_W'(1) && y == hm1) begin
        px = DIM_W'(2);
      end else if (x == '0) begin
        if (ye) px = DIM_W'(1); else py = yp;
      end else begin
        if (ye) py = yp; else px = '0;
      end
    end
  end

  // Status and output select; errors give zero coordinates
  always_comb begin
    if (w == DIM_W'(1) && h == DIM_W'(1)) begin
      stat   = ST_ONE_NODE;
      nb_col = '0;
      nb_row = '0;
    end else if (x >= w || y >= h) begin
      stat   = ST_OUTSIDE;
      nb_col = '0;
      nb_row = '0;
    end else begin
      stat   = ST_OK;
      nb_col = fwd ? nx[COORD_W-1:0] : px[COORD_W-1:0];
      nb_row = fwd ? ny[COORD_W-1:0] : py[COORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== tb/mrn_ring_checker.sv =====
// Checker for the mesh ring neighbour block: follows and checks the size registers,
// predicts the ring neighbour of every query transfer and compares each result field.
// Depends on mrn_pkg.
`timescale 1ns / 1ps

module mrn_ring_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [mrn_pkg::COORD_W-1:0] node_col,
  input  logic [mrn_pkg::COORD_W-1:0] node_row,
  input  logic                        toward_next,
  input  logic                        done,
  input  logic [mrn_pkg::ID_W-1:0]    neighbor_id,
  input  logic [mrn_pkg::COORD_W-1:0] neighbor_col,
  input  logic [mrn_pkg::COORD_W-1:0] neighbor_row,
  input  logic [1:0]                  status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          outstanding
);
  import mrn_pkg::*;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    status_t            st;
  } neighbour_t;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  neighbour_t       pending_neighbours[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Zero counts as one, anything above the largest size as the largest size
  function automatic int clamp_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // Next node along the ring
  function automatic void ring_successor(input int w, input int h, input int x, input int y,
                                         output int nx, output int ny);
    int cx;
    int cy;
    bit xe;
    bit ye;
    cx = x;
    cy = y;
    xe = (x % 2 == 0);
    ye = (y % 2 == 0);
    if (w == 1) begin
      cy = (y == h - 1) ? 0 : y + 1;
    end else if (h == 1) begin
      cx = (x == w - 1) ? 0 : x + 1;
    end else if (h == 2) begin
      if (y == 0) begin
        if (x == w - 1) cy = 1; else cx = x + 1;
      end else begin
        if (x == 0) cy = 0; else cx = x - 1;
      end
    end else if (w == 2) begin
      if (x == 0) begin
        if (y == 0) cx = 1; else cy = y - 1;
      end else begin
        if (y == h - 1) cx = 0; else cy = y + 1;
      end
    end else if (w % 2 == 0) begin
      // even width: top row rightwards, then a vertical snake back
      if (y == 0) begin
        if (x == w - 1) cy = 1; else cx = x + 1;
      end else if (y == 1) begin
        if (x == 0) cy = 0;
        else if (x == w - 1) cy = 2;
        else if (xe) cx = x - 1;
        else cy = 2;
      end else if (y == h - 1) begin
        if (xe) cy = y - 1; else cx = x - 1;
      end else begin
        if (xe) cy = y - 1; else cy = y + 1;
      end
    end else if (h % 2 == 0) begin
      // even height: the transposed layout
      if (x == 0) begin
        if (y == 0) cx = 1; else cy = y - 1;
      end else if (x == 1) begin
        if (y == 0) cx = 2;
        else if (y == h - 1) cx = 0;
        else if (ye) cx = 2;
        else cy = y + 1;
      end else if (x == w - 1) begin
        if (ye) cy = y + 1; else cx = x - 1;
      end else begin
        if (ye) cx = x + 1; else cx = x - 1;
      end
    end else begin
      // odd by odd: snake closed by the diagonal step from (1,1) to (0,0)
      if (y == 0) begin
        if (x == w - 1) cy = 1; else cx = x + 1;
      end else if (x > 1) begin
        if (y == 1) begin
          if (x == w - 1 || xe) cy = 2; else cx = x - 1;
        end else if (y == h - 1) begin
          if (xe) cx = x - 1; else cy = y - 1;
        end else begin
          if (xe) cy = y + 1; else cy = y - 1;
        end
      end else if (x == 1 && y == 1) begin
        cx = 0;
        cy = 0;
      end else if (x == 1 && y == h - 1) begin
        cx = 0;
      end else if (x == 0) begin
        if (ye) cy = y - 1; else cx = 1;
      end else begin
        if (ye) cx = 0; else cy = y - 1;
      end
    end
    nx = cx;
    ny = cy;
  endfunction

  // Previous node along the ring, the inverse of the step above
  function automatic void ring_predecessor(input int w, input int h, input int x, input int y,
                                           output int nx, output int ny);
    int cx;
    int cy;
    bit xe;
    bit ye;
    cx = x;
    cy = y;
    xe = (x % 2 == 0);
    ye = (y % 2 == 0);
    if (w == 1) begin
      cy = (y == 0) ? h - 1 : y - 1;
    end else if (h == 1) begin
      cx = (x == 0) ? w - 1 : x - 1;
    end else if (h == 2) begin
      if (y == 0) begin
        if (x == 0) cy = 1; else cx = x - 1;
      end else begin
        if (x == w - 1) cy = 0; else cx = x + 1;
      end
    end else if (w == 2) begin
      if (x == 0) begin
        if (y == h - 1) cx = 1; else cy = y + 1;
      end else begin
        if (y == 0) cx = 0; else cy = y - 1;
      end
    end else if (w % 2 == 0) begin
      if (y == 0) begin
        if (x == 0) cy = 1; else cx = x - 1;
      end else if (y == 1) begin
        if (x == 0) cy = 2;
        else if (x == w - 1) cy = 0;
        else if (xe) cy = 2;
        else cx = x + 1;
      end else if (y == h - 1) begin
        if (xe) cx = x + 1; else cy = y - 1;
      end else begin
        if (xe) cy = y + 1; else cy = y - 1;
      end
    end else if (h % 2 == 0) begin
      if (x == 0) begin
        if (y == h - 1) cx = 1; else cy = y + 1;
      end else if (x == 1) begin
        if (y == 0) cx = 0;
        else if (y == h - 1) cx = 2;
        else if (ye) cy = y - 1;
        else cx = 2;
      end else if (x == w - 1) begin
        if (ye) cx = x - 1; else cy = y - 1;
      end else begin
        if (ye) cx = x - 1; else cx = x + 1;
      end
    end else begin
      if (y == 0) begin
        if (x == 0) begin
          cx = 1;
          cy = 1;
        end else begin
          cx = x - 1;
        end
      end else if (x > 1) begin
        if (y == 1) begin
          if (x == w - 1) cy = 0;
          else if (xe) cx = x + 1;
          else cy = 2;
        end else if (y == h - 1) begin
          if (xe) cy = y - 1; else cx = x + 1;
        end else begin
          if (xe) cy = y - 1; else cy = y + 1;
        end
      end else if (x == 1 && y == 1) begin
        cx = 0;
      end else if (x == 1 && y == h - 1) begin
        cx = 2;
      end else if (x == 0) begin
        if (ye) cx = 1; else cy = y + 1;
      end else begin
        if (ye) cy = y + 1; else cx = 0;
      end
    end
    nx = cx;
    ny = cy;
  endfunction

  // Full answer to one query under the current sizes
  function automatic neighbour_t predict_neighbour(input logic [DIM_W-1:0] wr,
                                                   input logic [DIM_W-1:0] hr,
                                                   input logic [COORD_W-1:0] col,
                                                   input logic [COORD_W-1:0] row,
                                                   input logic fwd);
    int         w;
    int         h;
    int         x;
    int         y;
    int         nx;
    int         ny;
    neighbour_t r;
    w    = clamp_dim(wr);
    h    = clamp_dim(hr);
    x    = int'(col);
    y    = int'(row);
    nx   = 0;
    ny   = 0;
    r.st = ST_OK;
    // one-node grid takes priority over the coordinate range
    if (w <= 1 && h <= 1) r.st = ST_ONE_NODE;
    else if (x >= w || y >= h) r.st = ST_OUTSIDE;
    else if (fwd) ring_successor(w, h, x, y, nx, ny);
    else ring_predecessor(w, h, x, y, nx, ny);
    r.col = COORD_W'(nx);
    r.row = COORD_W'(ny);
    r.id  = (r.st == ST_OK) ? ID_W'(ny * w + nx) : '0;
    return r;
  endfunction

  // Register tracking, prediction on each query transfer, comparison on each result
  always @(posedge clk) begin
    neighbour_t want;
    logic [31:0] reg_value;
    if (rst) begin
      width_reg  = DIM_W'(2);
      height_reg = DIM_W'(2);
      pending_neighbours.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_GRID_WIDTH) width_reg = pwdata[DIM_W-1:0];
          else height_reg = pwdata[DIM_W-1:0];
        end else begin
          reg_value = (paddr[2] == REG_GRID_WIDTH) ? 32'(width_reg) : 32'(height_reg);
          if (prdata !== reg_value) begin
            $error("prdata: expected %0d, got %0d", reg_value, prdata);
            fail_count++;
          end
        end
      end
      if (start && !busy)
        pending_neighbours.push_back(predict_neighbour(width_reg, height_reg,
                                                       node_col, node_row, toward_next));
      if (done) begin
        if (pending_neighbours.size() == 0) begin
          $error("result with no query outstanding");
          fail_count++;
        end else begin
          want = pending_neighbours.pop_front();
          if (neighbor_id !== want.id) begin
            $error("neighbor_id: expected %0d, got %0d", want.id, neighbor_id);
            fail_count++;
          end
          if (neighbor_col !== want.col) begin
            $error("neighbor_col: expected %0d, got %0d", want.col, neighbor_col);
            fail_count++;
          end
          if (neighbor_row !== want.row) begin
            $error("neighbor_row: expected %0d, got %0d", want.row, neighbor_row);
            fail_count++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_count++;
          end
        end
      end
    end
    outstanding <= pending_neighbours.size();
  end

endmodule

// ===== tb/tb_mesh_ring_neighbor.sv =====
// Top of the mesh ring neighbour testbench: clock, reset, size register writes,
// directed and random queries, and the verdict. Depends on mrn_pkg,
// mesh_ring_neighbor and mrn_ring_checker.
`timescale 1ns / 1ps

module tb_mesh_ring_neighbor;
  import mrn_pkg::*;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [COORD_W-1:0]  node_col;
  logic [COORD_W-1:0]  node_row;
  logic                toward_next;
  logic                done;
  logic [ID_W-1:0]     neighbor_id;
  logic [COORD_W-1:0]  neighbor_col;
  logic [COORD_W-1:0]  neighbor_row;
  logic [1:0]          status;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  fail_count;
  int                  outstanding;

  // effective sizes, used only to aim the coordinates
  int                  cur_w;
  int                  cur_h;
  bit                  no_gaps;

  // size settings of the random phases, extremes and every layout among them
  int phase_w[24] = '{1, 0, 1, 64, 1, 9, 5, 2, 2, 6, 64, 5,
                      63, 3, 7, 63, 64, 127, 65, 0, 2, 64, 4, 3};
  int phase_h[24] = '{1, 0, 64, 1, 7, 1, 2, 9, 2, 5, 63, 6,
                      64, 3, 5, 63, 64, 127, 3, 12, 64, 2, 4, 0};

  mesh_ring_neighbor dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .node_col     (node_col),
    .node_row     (node_row),
    .toward_next  (toward_next),
    .done         (done),
    .neighbor_id  (neighbor_id),
    .neighbor_col (neighbor_col),
    .neighbor_row (neighbor_row),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  mrn_ring_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .node_col     (node_col),
    .node_row     (node_row),
    .toward_next  (toward_next),
    .done         (done),
    .neighbor_id  (neighbor_id),
    .neighbor_col (neighbor_col),
    .neighbor_row (neighbor_row),
    .status       (status),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int clamp_size(input int v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Mostly inside the grid, often on its edges, now and then anywhere
  function automatic int pick_coord(input int size);
    int r;
    int v;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = 1;
        2: v = size - 2;
        default: v = size - 1;
      endcase
      if (v < 0) v = 0;
    end else if (r < 9) begin
      v = $urandom_range(0, size - 1);
    end else begin
      v = $urandom_range(0, 63);
    end
    return v;
  endfunction

  // One register write, then a read back; upper data bits sometimes junk
  task automatic write_size(input logic idx, input logic [DIM_W-1:0] value);
    logic [31:0] data;
    data = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
    data[DIM_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Sizes change only once every result is out and the pipeline has drained
  task automatic configure(input int w, input int h);
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_size(REG_GRID_WIDTH, DIM_W'(w));
    write_size(REG_GRID_HEIGHT, DIM_W'(h));
    cur_w = clamp_size(w);
    cur_h = clamp_size(h);
  endtask

  // One query transfer; start stays up for a back-to-back follower
  task automatic send_query(input int col, input int row, input bit fwd);
    start       <= 1'b1;
    node_col    <= COORD_W'(col);
    node_row    <= COORD_W'(row);
    toward_next <= fwd;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 9);
    if (no_gaps || r < 6) n = 0;
    else if (r < 9) n = $urandom_range(1, 3);
    else n = $urandom_range(5, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_phase(input int w, input int h, input int count);
    configure(w, h);
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      send_query(pick_coord(cur_w), pick_coord(cur_h), 1'($urandom_range(0, 1)));
      idle_gap();
    end
  endtask

  // Stimulus and verdict
  initial begin
    int waited;
    rst         <= 1'b1;
    start       <= 1'b0;
    node_col    <= '0;
    node_row    <= '0;
    toward_next <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    cur_w       = 2;
    cur_h       = 2;
    no_gaps     = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset sizes 2 by 2: every node both ways, then outside the grid
    for (int i = 0; i < 8; i++) send_query(i % 2, (i / 2) % 2, 1'(i / 4));
    send_query(63, 63, 1'b1);
    send_query(2, 0, 1'b0);
    // one-node grid, also with coordinates outside it
    configure(1, 1);
    send_query(0, 0, 1'b1);
    send_query(63, 63, 1'b0);
    // odd by odd: the diagonal closing step in both directions
    configure(3, 3);
    send_query(1, 1, 1'b1);
    send_query(0, 0, 1'b0);
    send_query(2, 2, 1'b1);
    send_query(0, 2, 1'b0);
    // largest mesh, far corners
    configure(64, 64);
    send_query(63, 63, 1'b1);
    send_query(63, 0, 1'b0);
    send_query(0, 63, 1'b1);

    foreach (phase_w[i]) random_phase(phase_w[i], phase_h[i], 64);
    repeat (6) begin
      if ($urandom_range(0, 3) == 0)
        random_phase($urandom_range(0, 127), $urandom_range(0, 127), 64);
      else
        random_phase($urandom_range(1, 12), $urandom_range(1, 12), 64);
    end

    // drain
    start <= 1'b0;
    waited = 0;
    @(posedge clk);
    while (outstanding != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== mesh_ring_neighbor.f =====
src/mrn_pkg.sv
src/mrn_cfg_regs.sv
src/mrn_ring_step.sv
src/mesh_ring_neighbor.sv
tb/mrn_ring_checker.sv
tb/tb_mesh_ring_neighbor.sv
